>>> hdl/cldr_pkg.sv
// cldr_pkg: widths, register indexes, reset values and shared types for the
// current limited pi drive regulator; used by every file of the block
package cldr_pkg;

  localparam int unsigned ReqW   = 8;
  localparam int unsigned CurW   = 8;
  localparam int unsigned DriveW = 8;
  localparam int unsigned LimW   = 12;
  localparam int unsigned IntW   = 9;
  localparam int unsigned AccW   = 14;
  localparam int unsigned NormW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned AccShift = 6;

  typedef enum logic [CfgIdxW-1:0] {
    RegLowDrive   = 3'd0,
    RegLowCurrent = 3'd1,
    RegCurLimit   = 3'd2,
    RegIntLimit   = 3'd3,
    RegAccMax     = 3'd4
  } cfg_reg_e;

  localparam logic [7:0]      LowDriveRst   = 8'd25;
  localparam logic [7:0]      LowCurrentRst = 8'd25;
  localparam logic [LimW-1:0] CurLimitRst   = 12'd256;
  localparam logic [7:0]      IntLimitRst   = 8'd255;
  localparam logic [AccW-1:0] AccMaxRst     = 14'd16383;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hdl/cldr_in_if.sv
// cldr_in_if: input channel of the regulator, one item per control tick
// depends on cldr_pkg for field widths
interface cldr_in_if;
  logic                      valid;
  logic                      ready;
  logic [cldr_pkg::ReqW-1:0] wanted_acceleration;
  logic [cldr_pkg::CurW-1:0] actual_current;

  modport source (output valid, output wanted_acceleration, output actual_current,
                  input ready);
  modport sink (input valid, input wanted_acceleration, input actual_current,
                output ready);
endinterface

>>> hdl/cldr_out_if.sv
// cldr_out_if: result channel of the regulator, one drive item per tick
// depends on cldr_pkg for field widths
interface cldr_out_if;
  logic                        valid;
  logic                        ready;
  logic [cldr_pkg::DriveW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

>>> hdl/cldr_div.sv
// cldr_div: restoring divider, one quotient bit per cycle
// dividend 16 bits by an 8-bit nonzero divisor; depends on cldr_pkg
module cldr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cldr_pkg::NormW-1:0]  dividend_i,
  input  logic [cldr_pkg::DriveW-1:0] divisor_i,
  output cldr_pkg::div_status_t       status_o,
  output logic [cldr_pkg::NormW-1:0]  quotient_o
);

  logic [cldr_pkg::NormW-1:0]  dvd_q;
  logic [cldr_pkg::DriveW-1:0] rem_q;
  logic [cldr_pkg::DriveW-1:0] dvs_q;
  logic [3:0]                  cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [cldr_pkg::DriveW:0]   rem_sh;
  logic [cldr_pkg::DriveW+1:0] diff;
  logic                        qbit;

  assign rem_sh = {rem_q, dvd_q[cldr_pkg::NormW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign qbit   = ~diff[cldr_pkg::DriveW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[cldr_pkg::NormW-2:0], qbit};
        rem_q <= qbit ? diff[cldr_pkg::DriveW-1:0] : rem_sh[cldr_pkg::DriveW-1:0];
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule

>>> hdl/current_limited_pi_drive_regulator_top.sv
// current_limited_pi_drive_regulator_top: sequencer, sums and config registers
// depends on cldr_pkg, cldr_in_if, cldr_out_if and cldr_div
//
//   port      dir   kind          contents
//   in_i      in    valid/ready   wanted_acceleration, actual_current
//   out_o     out   valid/ready   drive
//   cfg_*_i   in    write only    five registers by index
//
// zero request, bypass and zero last drive items go from idle straight to the result step
// regulated items pass start, 16 divider steps, limit check, inner sum,
// accumulator and result steps; over-limit items skip the sums
// reset clears all state and loads the register defaults
// a result waits in the output register until taken; the next item is taken
// once the result has moved there
module current_limited_pi_drive_regulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cldr_in_if.sink                       in_i,
  cldr_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [cldr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cldr_pkg::CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StInner,
    StAcc,
    StDone
  } state_e;

  state_e state_q;

  logic [7:0]                  low_drive_q;
  logic [7:0]                  low_current_q;
  logic [cldr_pkg::LimW-1:0]   cur_limit_q;
  logic [7:0]                  int_limit_q;
  logic [cldr_pkg::AccW-1:0]   acc_max_q;

  logic [cldr_pkg::DriveW-1:0] last_drive_q;
  logic signed [cldr_pkg::IntW-1:0] inner_q;
  logic [cldr_pkg::AccW-1:0]   acc_q;
  logic [cldr_pkg::ReqW-1:0]   req_q;
  logic signed [12:0]          delta_q;
  logic [cldr_pkg::DriveW-1:0] drive_q;
  logic                        out_valid_q;
  logic [cldr_pkg::DriveW-1:0] out_drive_q;

  logic                        in_fire;
  logic                        bypass;
  logic                        div_start;
  cldr_pkg::div_status_t       div_status;
  logic [cldr_pkg::NormW-1:0]  quotient;
  logic                        over_limit;
  logic signed [12:0]          delta_d;
  logic signed [13:0]          inner_sum;
  logic signed [13:0]          lim_pos;
  logic signed [cldr_pkg::IntW-1:0] inner_d;
  logic signed [15:0]          acc_sum;
  logic [cldr_pkg::AccW-1:0]   acc_d;
  logic                        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_drive_q   <= cldr_pkg::LowDriveRst;
      low_current_q <= cldr_pkg::LowCurrentRst;
      cur_limit_q   <= cldr_pkg::CurLimitRst;
      int_limit_q   <= cldr_pkg::IntLimitRst;
      acc_max_q     <= cldr_pkg::AccMaxRst;
    end else if (cfg_we_i) begin
      case (cldr_pkg::cfg_reg_e'(cfg_idx_i))
        cldr_pkg::RegLowDrive:   low_drive_q   <= cfg_data_i[7:0];
        cldr_pkg::RegLowCurrent: low_current_q <= cfg_data_i[7:0];
        cldr_pkg::RegCurLimit:   cur_limit_q   <= cfg_data_i[cldr_pkg::LimW-1:0];
        cldr_pkg::RegIntLimit:   int_limit_q   <= cfg_data_i[7:0];
        cldr_pkg::RegAccMax:     acc_max_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign bypass     = (last_drive_q < low_drive_q) || (in_i.actual_current < low_current_q);
  assign div_start  = in_fire && (in_i.wanted_acceleration != '0) && !bypass &&
                      (last_drive_q != '0);

  cldr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({in_i.actual_current, 8'h00}),
    .divisor_i  (last_drive_q),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  assign over_limit = quotient > {4'b0000, cur_limit_q};
  assign delta_d    = $signed({5'b00000, req_q}) - $signed({1'b0, quotient[cldr_pkg::LimW-1:0]});

  assign inner_sum = {{5{inner_q[cldr_pkg::IntW-1]}}, inner_q} + {delta_q[12], delta_q};
  assign lim_pos   = $signed({6'b000000, int_limit_q});

  always_comb begin
    if (inner_sum > lim_pos) begin
      inner_d = $signed({1'b0, int_limit_q});
    end else if (inner_sum < -lim_pos) begin
      inner_d = -$signed({1'b0, int_limit_q});
    end else begin
      inner_d = inner_sum[cldr_pkg::IntW-1:0];
    end
  end

  assign acc_sum = $signed({2'b00, acc_q}) + {{7{inner_q[cldr_pkg::IntW-1]}}, inner_q} +
                   {{3{delta_q[12]}}, delta_q};

  always_comb begin
    if (acc_sum < 16'sd0) begin
      acc_d = '0;
    end else if (acc_sum > $signed({2'b00, acc_max_q})) begin
      acc_d = acc_max_q;
    end else begin
      acc_d = acc_sum[cldr_pkg::AccW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      last_drive_q <= '0;
      inner_q      <= '0;
      acc_q        <= '0;
      req_q        <= '0;
      delta_q      <= '0;
      drive_q      <= '0;
      out_valid_q  <= 1'b0;
      out_drive_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            req_q <= in_i.wanted_acceleration;
            if (in_i.wanted_acceleration == '0) begin
              inner_q <= '0;
              acc_q   <= '0;
              drive_q <= '0;
              state_q <= StDone;
            end else if (bypass) begin
              inner_q <= '0;
              acc_q   <= {in_i.wanted_acceleration, 6'b000000};
              drive_q <= in_i.wanted_acceleration;
              state_q <= StDone;
            end else if (last_drive_q == '0) begin
              drive_q <= acc_q[cldr_pkg::AccW-1:cldr_pkg::AccShift];
              state_q <= StDone;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_status.done) begin
            if (over_limit) begin
              drive_q <= acc_q[cldr_pkg::AccW-1:cldr_pkg::AccShift];
              state_q <= StDone;
            end else begin
              delta_q <= delta_d;
              state_q <= StInner;
            end
          end
        end
        StInner: begin
          inner_q <= inner_d;
          state_q <= StAcc;
        end
        StAcc: begin
          acc_q   <= acc_d;
          drive_q <= acc_d[cldr_pkg::AccW-1:cldr_pkg::AccShift];
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_drive_q  <= drive_q;
            last_drive_q <= drive_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.drive = out_drive_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == StIdle) && !div_status.busy)
    else $error("divider started while busy");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.busy |-> (state_q == StDiv))
    else $error("divider busy outside divide step");

  a_out_tracks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_drive_q == last_drive_q))
    else $error("pending drive differs from kept drive");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("item taken while previous item still at work");
`endif

endmodule

>>> tb/sv/tb_current_limited_pi_drive_regulator_top.sv
// tb_current_limited_pi_drive_regulator_top: self-checking bench for the regulator top;
// sends control ticks and register writes, predicts every drive item and checks them in order
// depends on cldr_pkg, cldr_in_if, cldr_out_if and current_limited_pi_drive_regulator_top
module tb_current_limited_pi_drive_regulator_top;
  import cldr_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  cldr_in_if  in_if ();
  cldr_out_if out_if ();

  current_limited_pi_drive_regulator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state and register copies
  int thr_drive;
  int thr_current;
  int cur_limit;
  int int_limit;
  int acc_max;
  int last_drv;
  int int_sum;
  int drv_acc;

  logic [DriveW-1:0] drive_q[$];
  logic [DriveW-1:0] want_drive;
  int                mismatch_cnt;
  bit                idle_on;
  bit                long_hold;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_current_limited_pi_drive_regulator_top NOT OK");
    $finish;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [DriveW-1:0] regulate_tick(input logic [ReqW-1:0] req,
                                                      input logic [CurW-1:0] cur);
    int r;
    int c;
    int norm;
    int delta;
    logic [DriveW-1:0] drv;
    r = req;
    c = cur;
    if (r == 0) begin
      int_sum = 0;
      drv_acc = 0;
      drv = '0;
    end else if (last_drv < thr_drive || c < thr_current) begin
      drv_acc = r * 64;
      int_sum = 0;
      drv = req;
    end else begin
      // a zero divisor saturates the normalised current
      if (last_drv == 0) begin
        norm = 65535;
      end else begin
        norm = ((c * 256) / last_drv) & 16'hFFFF;
      end
      if (norm <= cur_limit) begin
        delta = r - norm;
        int_sum = clip(int_sum + delta, -int_limit, int_limit);
        drv_acc = clip(drv_acc + int_sum + delta, 0, acc_max);
      end
      drv = DriveW'(drv_acc >> AccShift);
    end
    last_drv = drv;
    return drv;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("mismatch: %s got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected drive item", out_if.drive, 0);
      end else begin
        want_drive = drive_q.pop_front();
        if (out_if.drive !== want_drive) begin
          report_mismatch("drive", out_if.drive, want_drive);
        end
      end
    end
  end

  // result side ready, with random bursts and one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [ReqW-1:0] req, input logic [CurW-1:0] cur);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid               <= 1'b1;
    in_if.wanted_acceleration <= req;
    in_if.actual_current      <= cur;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    drive_q.push_back(regulate_tick(req, cur));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk_i);
    case (idx)
      RegLowDrive:   thr_drive   = val & 8'hFF;
      RegLowCurrent: thr_current = val & 8'hFF;
      RegCurLimit:   cur_limit   = val & 12'hFFF;
      RegIntLimit:   int_limit   = val & 8'hFF;
      RegAccMax:     acc_max     = val & 14'h3FFF;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int ld, input int lc, input int cl, input int il,
                                input int am);
    write_reg(RegLowDrive, ld);
    write_reg(RegLowCurrent, lc);
    write_reg(RegCurLimit, cl);
    write_reg(RegIntLimit, il);
    write_reg(RegAccMax, am);
  endtask

  // mostly a bypass tick followed by regulated ticks with current near the limit
  task automatic run_mixed(input int n);
    int sent;
    int len;
    int k;
    int cur;
    logic [ReqW-1:0] req;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        req = ReqW'($urandom_range(1, 255));
        if (thr_current > 0) begin
          cur = $urandom_range(0, thr_current - 1);
        end else begin
          cur = $urandom_range(0, 255);
        end
        send_item(req, CurW'(cur));
        sent++;
        len = $urandom_range(2, 12);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) req = ReqW'($urandom_range(1, 255));
          k = $urandom_range(0, cur_limit + cur_limit / 4 + 16);
          cur = (last_drv * k) / 256;
          if (cur > 255) cur = 255;
          if ($urandom_range(0, 9) == 0) cur = $urandom_range(0, 255);
          send_item(req, CurW'(cur));
          sent++;
        end
      end else begin
        req = ($urandom_range(0, 9) == 0) ? '0 : ReqW'($urandom);
        send_item(req, CurW'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_defaults();
    send_item(8'd0, 8'd0);
    send_item(8'd255, 8'd0);
    send_item(8'd255, 8'd255);
    send_item(8'd255, 8'd255);
    send_item(8'd1, 8'd255);
    send_item(8'd128, 8'd100);
    send_item(8'd0, 8'd255);
    send_item(8'd30, 8'd10);
    send_item(8'd30, 8'd255);
    send_item(8'd255, 8'd24);
    send_item(8'd255, 8'd25);
    send_item(8'd255, 8'd25);
  endtask

  task automatic test_zero_divisor();
    wait_drained();
    apply_settings(0, 0, LowCurrentRst, IntLimitRst, AccMaxRst);
    send_item(8'd0, 8'd0);
    send_item(8'd50, 8'd0);
    send_item(8'd255, 8'd255);
    send_item(8'd0, 8'd255);
    wait_drained();
    write_reg(RegLowCurrent, 255);
    send_item(8'd77, 8'd254);
  endtask

  task automatic test_lowered_limits();
    wait_drained();
    apply_settings(LowDriveRst, LowCurrentRst, CurLimitRst, IntLimitRst, AccMaxRst);
    send_item(8'd200, 8'd0);
    send_item(8'd255, 8'd30);
    wait_drained();
    write_reg(RegIntLimit, 3);
    write_reg(RegAccMax, 1000);
    send_item(8'd255, 8'd30);
    send_item(8'd100, 8'd0);
    send_item(8'd10, 8'd200);
    wait_drained();
    apply_settings(LowDriveRst, LowCurrentRst, 0, 0, 0);
    send_item(8'd5, 8'd25);
    wait_drained();
    write_reg(RegCurLimit, 4095);
    send_item(8'd1, 8'd255);
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 7; s++) begin
      wait_drained();
      case (s)
        0: apply_settings(0, 0, 0, 0, 0);
        1: apply_settings(255, 255, 4095, 255, 16383);
        2: apply_settings(LowDriveRst, LowCurrentRst, CurLimitRst, IntLimitRst, AccMaxRst);
        3: apply_settings($urandom_range(0, 60), $urandom_range(0, 60),
                          $urandom_range(0, 4095), $urandom_range(0, 255),
                          $urandom_range(0, 16383));
        default: apply_settings($urandom_range(0, 60), $urandom_range(0, 60),
                                $urandom_range(64, 600), $urandom_range(0, 255),
                                $urandom_range(4000, 16383));
      endcase
      run_mixed(180);
    end
  endtask

  task automatic test_output_stall();
    wait_drained();
    apply_settings(20, 20, 300, 200, 16383);
    long_hold = 1'b1;
    run_mixed(40);
  endtask

  task automatic test_drain_pause();
    run_mixed(40);
    wait_drained();
    run_mixed(40);
  endtask

  task automatic test_steady_flow();
    wait_drained();
    apply_settings($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(100, 500),
                   $urandom_range(0, 255), $urandom_range(8000, 16383));
    idle_on = 1'b0;
    run_mixed(150);
  endtask

  initial begin
    in_if.valid               <= 1'b0;
    in_if.wanted_acceleration <= '0;
    in_if.actual_current      <= '0;
    cfg_we                    <= 1'b0;
    cfg_idx                   <= RegLowDrive;
    cfg_data                  <= '0;
    rst_ni                    <= 1'b0;
    mismatch_cnt = 0;
    idle_on      = 1'b1;
    long_hold    = 1'b0;
    thr_drive    = LowDriveRst;
    thr_current  = LowCurrentRst;
    cur_limit    = CurLimitRst;
    int_limit    = IntLimitRst;
    acc_max      = AccMaxRst;
    last_drv     = 0;
    int_sum      = 0;
    drv_acc      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_defaults();
    test_zero_divisor();
    test_lowered_limits();
    test_random_settings();
    test_output_stall();
    test_drain_pause();
    test_steady_flow();

    wait_drained();
    if (mismatch_cnt == 0 && drive_q.size() == 0) begin
      $display("tb_current_limited_pi_drive_regulator_top OK");
    end else begin
      $display("tb_current_limited_pi_drive_regulator_top NOT OK");
    end
    $finish;
  end

endmodule
